// ===== hw/rtl/prid_pkg.sv =====
`default_nettype none
package prid_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int DIM_W   = 11;
  localparam int COL_W   = 10;
  localparam int ROW_W   = 10;
  localparam int LEN_W   = 8;
  localparam int COLOR_W = 24;
  localparam int PIX_W   = 21;

  localparam int PAL_DEPTH  = 256;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  localparam logic [1:0] OP_PAL   = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  typedef struct packed {
    logic [COLOR_W-1:0] pal_color;
    logic [7:0]         pal_index;
    logic [7:0]         byte_value;
    logic [1:0]         op;
  } in_beat_t;

  typedef struct packed {
    logic               is_start;
    logic [LEN_W-1:0]   count;
    logic [COLOR_W-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic               image_done;
    logic               last_of_item;
    logic [COLOR_W-1:0] color;
    logic [LEN_W-1:0]   length;
    logic [COL_W-1:0]   column;
    logic [ROW_W-1:0]   row;
  } seg_t;

endpackage
`default_nettype wire

// ===== hw/rtl/palette_rle_image_decoder_core.sv =====
// Palette run-length image decoder.
// s_* channel: one beat per item: palette write, stream byte or image start.
// m_* channel: one beat per row segment of one colour; tlast marks the last
// segment caused by an input beat, tuser marks the segment finishing row 0.
// APB port: image_width at 0x0, image_height at 0x4; read back returns them.
// The size is taken when a start beat is accepted.
// An index byte is registered with its palette read at the accepting edge, then
// enters the queue and then reaches the output register, where m_tvalid rises;
// a full queue or a stalled output holds it between these steps. Input takes
// one beat a cycle while the four-entry command queue has room; the segment
// unit emits one segment a cycle while the output register is free, so a run
// crossing rows is split into one segment per row.
// Reset clears the packet state, the queue and the output valid flag, and leaves
// the decoder finished until a start beat; palette contents are kept as they are
// and must be written before use.
// A stalled m_tready holds the output beat; the queue fills, the command stage
// holds its beat and s_tready falls. Headers, palette writes and starts still
// pass while the command stage is empty.
`default_nettype none
module palette_rle_image_decoder_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // op[1:0], byte_value[9:2], pal_index[17:10], pal_color[41:18], zero fill
  input  wire logic [47:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // row[9:0], column[19:10], length[27:20], color[51:28], zero fill
  output logic      [55:0] m_tdata,
  output logic             m_tlast,
  // image_done
  output logic             m_tuser,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic [prid_pkg::DIM_W-1:0] image_width;
  logic [prid_pkg::DIM_W-1:0] image_height;
  logic                       cfg_write;

  logic                       push;
  prid_pkg::cmd_t             push_cmd;
  logic                       fifo_full;
  logic                       pop;
  logic                       head_valid;
  prid_pkg::cmd_t             head;
  prid_pkg::seg_t             seg;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= prid_pkg::DIM_W'(3);
      image_height <= prid_pkg::DIM_W'(1);
    end else if (cfg_write) begin
      if (paddr[2]) begin
        image_height <= pwdata[prid_pkg::DIM_W-1:0];
      end else begin
        image_width <= pwdata[prid_pkg::DIM_W-1:0];
      end
    end
  end

  assign prdata = paddr[2] ? {21'd0, image_height} : {21'd0, image_width};

  prid_front u_front (
    .clk          (clk),
    .rst          (rst),
    .s_valid      (s_tvalid),
    .s_ready      (s_tready),
    .s_beat       (prid_pkg::in_beat_t'(s_tdata[41:0])),
    .image_width  (image_width),
    .image_height (image_height),
    .push         (push),
    .push_cmd     (push_cmd),
    .fifo_full    (fifo_full)
  );

  prid_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (fifo_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  prid_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_seg    (seg)
  );

  assign m_tdata = {4'b0000, seg.color, seg.length, seg.column, seg.row};
  assign m_tlast = seg.last_of_item;
  assign m_tuser = seg.image_done;

endmodule
`default_nettype wire

// ===== hw/rtl/prid_ram.sv =====
`default_nettype none
module prid_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/prid_front.sv =====
`default_nettype none
module prid_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_valid,
  output logic                             s_ready,
  input  wire prid_pkg::in_beat_t          s_beat,
  input  wire logic [prid_pkg::DIM_W-1:0]  image_width,
  input  wire logic [prid_pkg::DIM_W-1:0]  image_height,
  output logic                             push,
  output prid_pkg::cmd_t                   push_cmd,
  input  wire logic                        fifo_full
);

  typedef enum logic [2:0] {
    M_HEADER = 3'b001,
    M_RAW    = 3'b010,
    M_RUN    = 3'b100
  } mode_t;

  mode_t                          mode, mode_next;
  logic [prid_pkg::LEN_W-1:0]     packet_left, packet_left_next;
  logic [prid_pkg::PIX_W-1:0]     remaining, remaining_next;
  logic                           s1_valid;
  prid_pkg::cmd_t                 s1_cmd, s1_cmd_next;
  logic [prid_pkg::COLOR_W-1:0]   ram_rdata;

  logic                           accept;
  logic                           stream;
  logic                           produce;
  logic                           start;
  logic [prid_pkg::LEN_W-1:0]     req;
  logic [prid_pkg::LEN_W-1:0]     clip;
  logic [prid_pkg::DIM_W-1:0]     sat_w;
  logic [prid_pkg::DIM_W-1:0]     sat_h;
  logic [2*prid_pkg::DIM_W-1:0]   area;

  assign s_ready = !s1_valid || !fifo_full;
  assign accept  = s_valid && s_ready;
  assign push    = s1_valid && !fifo_full;

  prid_ram #(
    .WIDTH (prid_pkg::COLOR_W),
    .DEPTH (prid_pkg::PAL_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (accept && s_beat.op == prid_pkg::OP_PAL),
    .waddr (s_beat.pal_index),
    .wdata (s_beat.pal_color),
    .re    (accept),
    .raddr (s_beat.byte_value),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (image_width < prid_pkg::DIM_W'(3)) begin
      sat_w = prid_pkg::DIM_W'(3);
    end else if (image_width > prid_pkg::DIM_W'(prid_pkg::MAX_WIDTH)) begin
      sat_w = prid_pkg::DIM_W'(prid_pkg::MAX_WIDTH);
    end else begin
      sat_w = image_width;
    end
    if (image_height < prid_pkg::DIM_W'(1)) begin
      sat_h = prid_pkg::DIM_W'(1);
    end else if (image_height > prid_pkg::DIM_W'(prid_pkg::MAX_HEIGHT)) begin
      sat_h = prid_pkg::DIM_W'(prid_pkg::MAX_HEIGHT);
    end else begin
      sat_h = image_height;
    end
  end

  assign area    = sat_w * sat_h;
  assign start   = s_beat.op == prid_pkg::OP_START;
  assign stream  = s_beat.op == prid_pkg::OP_BYTE && remaining != '0;
  assign produce = stream && mode != M_HEADER;
  assign req     = (mode == M_RAW) ? prid_pkg::LEN_W'(1) : packet_left;
  assign clip    = (remaining < prid_pkg::PIX_W'(req)) ? remaining[prid_pkg::LEN_W-1:0] : req;

  always_comb begin
    mode_next        = mode;
    packet_left_next = packet_left;
    remaining_next   = remaining;
    s1_cmd_next      = s1_cmd;
    if (start) begin
      mode_next                 = M_HEADER;
      packet_left_next          = '0;
      remaining_next            = area[prid_pkg::PIX_W-1:0];
      s1_cmd_next.is_start      = 1'b1;
      s1_cmd_next.count         = '0;
      s1_cmd_next.data          = {3'b000, prid_pkg::ROW_W'(sat_h - 1'b1), sat_w};
    end else if (stream) begin
      s1_cmd_next.is_start = 1'b0;
      s1_cmd_next.count    = clip;
      s1_cmd_next.data     = '0;
      unique case (mode)
        M_HEADER: begin
          packet_left_next = {1'b0, s_beat.byte_value[6:0]} + 1'b1;
          mode_next        = s_beat.byte_value[7] ? M_RUN : M_RAW;
        end
        M_RAW: begin
          remaining_next   = remaining - prid_pkg::PIX_W'(clip);
          packet_left_next = packet_left - 1'b1;
          if (packet_left == prid_pkg::LEN_W'(1)) begin
            mode_next = M_HEADER;
          end
        end
        M_RUN: begin
          remaining_next   = remaining - prid_pkg::PIX_W'(clip);
          packet_left_next = '0;
          mode_next        = M_HEADER;
        end
        default: begin
          mode_next = M_HEADER;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= M_HEADER;
      packet_left <= '0;
      remaining   <= '0;
      s1_valid    <= 1'b0;
    end else if (accept) begin
      mode        <= mode_next;
      packet_left <= packet_left_next;
      remaining   <= remaining_next;
      s1_valid    <= produce || start;
    end else if (push) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd <= s1_cmd_next;
    end
  end

  always_comb begin
    push_cmd = s1_cmd;
    if (!s1_cmd.is_start) begin
      push_cmd.data = ram_rdata;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/prid_fifo.sv =====
`default_nettype none
module prid_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire prid_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                head_valid,
  output prid_pkg::cmd_t      head
);

  prid_pkg::cmd_t                 slots [prid_pkg::FIFO_DEPTH];
  logic [prid_pkg::FIFO_AW-1:0]   wr_ptr;
  logic [prid_pkg::FIFO_AW-1:0]   rd_ptr;
  logic [prid_pkg::FIFO_AW:0]     count;

  assign full       = count == (prid_pkg::FIFO_AW+1)'(prid_pkg::FIFO_DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/prid_back.sv =====
`default_nettype none
module prid_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           head_valid,
  input  wire prid_pkg::cmd_t head,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output prid_pkg::seg_t      out_seg
);

  logic [prid_pkg::DIM_W-1:0]   act_w;
  logic [prid_pkg::COL_W-1:0]   cur_col;
  logic [prid_pkg::ROW_W-1:0]   cur_row;
  logic                         active;
  logic [prid_pkg::LEN_W-1:0]   left;

  logic [prid_pkg::LEN_W-1:0]   eff_left;
  logic [prid_pkg::DIM_W-1:0]   room;
  logic [prid_pkg::LEN_W-1:0]   len;
  logic [prid_pkg::DIM_W-1:0]   col_sum;
  logic                         row_end;
  logic                         slot_free;
  logic                         emit;
  logic                         take_start;
  logic                         last_seg;

  assign eff_left   = active ? left : head.count;
  assign room       = act_w - {1'b0, cur_col};
  assign len        = (room < prid_pkg::DIM_W'(eff_left)) ? room[prid_pkg::LEN_W-1:0]
                                                          : eff_left;
  assign col_sum    = {1'b0, cur_col} + prid_pkg::DIM_W'(len);
  assign row_end    = col_sum == act_w;
  assign slot_free  = !out_valid || out_ready;
  assign take_start = head_valid && head.is_start;
  assign emit       = head_valid && !head.is_start && slot_free;
  assign last_seg   = len == eff_left;
  assign pop        = take_start || (emit && last_seg);

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        active    <= !last_seg;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (take_start) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_start) begin
      act_w   <= head.data[prid_pkg::DIM_W-1:0];
      cur_row <= head.data[prid_pkg::DIM_W +: prid_pkg::ROW_W];
      cur_col <= '0;
    end else if (emit) begin
      left                 <= eff_left - len;
      out_seg.row          <= cur_row;
      out_seg.column       <= cur_col;
      out_seg.length       <= len;
      out_seg.color        <= head.data;
      out_seg.last_of_item <= last_seg;
      out_seg.image_done   <= row_end && cur_row == '0;
      if (row_end) begin
        cur_col <= '0;
        if (cur_row != '0) begin
          cur_row <= cur_row - 1'b1;
        end
      end else begin
        cur_col <= col_sum[prid_pkg::COL_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
module testbench;
  import prid_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned QUIET_CYCLES = 16;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam logic [2:0]  WIDTH_ADDR   = 3'h0;
  localparam logic [2:0]  HEIGHT_ADDR  = 3'h4;
  localparam logic [7:0]  RUN_FLAG     = 8'h80;
  localparam logic [7:0]  COUNT_MASK   = 8'h7f;

  typedef enum logic [1:0] {AWAIT_HEADER, AWAIT_RAW, AWAIT_RUN} pkt_phase_e;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  palette_rle_image_decoder_core DUT (.*);

  // decoder shadow state
  logic [COLOR_W-1:0] pal_shadow [PAL_DEPTH];
  logic [DIM_W-1:0]   width_reg    = 11'd3;
  logic [DIM_W-1:0]   height_reg   = 11'd1;
  int unsigned        img_w        = 3;
  int unsigned        img_h        = 1;
  pkt_phase_e         pkt_phase    = AWAIT_HEADER;
  int unsigned        pkt_left     = 0;
  int unsigned        row_pos      = 0;
  int unsigned        col_pos      = 0;
  bit                 img_finished = 1'b1;
  seg_t               pending_segs [$];

  int unsigned tx_idle_pct  = 6;
  int unsigned rx_idle_pct  = 45;
  int unsigned cycle_count  = 0;
  int unsigned errors       = 0;
  int unsigned decoded      = 0;
  int unsigned segs_seen    = 0;
  int unsigned images_done  = 0;
  int unsigned size_changes = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d segments outstanding", cycle_count,
               pending_segs.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  function automatic int paint_run(input int unsigned pixels, input logic [COLOR_W-1:0] color);
    int          n;
    int unsigned span;
    seg_t        seg;
    n = 0;
    while (pixels > 0 && !img_finished) begin
      span = (pixels < img_w - col_pos) ? pixels : img_w - col_pos;
      seg = '0;
      seg.row = row_pos[ROW_W-1:0];
      seg.column = col_pos[COL_W-1:0];
      seg.length = span[LEN_W-1:0];
      seg.color = color;
      col_pos += span;
      pixels -= span;
      if (col_pos >= img_w) begin
        col_pos = 0;
        if (row_pos == 0) begin
          img_finished = 1'b1;
          seg.image_done = 1'b1;
        end else begin
          row_pos--;
        end
      end
      pending_segs.push_back(seg);
      n++;
    end
    return n;
  endfunction

  function automatic void decode_beat(input in_beat_t beat);
    int   n;
    seg_t tail;
    n = 0;
    case (beat.op)
      OP_PAL: begin
        pal_shadow[beat.pal_index] = beat.pal_color;
        decoded++;
      end
      OP_START: begin
        img_w = (width_reg < 3) ? 3 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
        img_h = (height_reg < 1) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
        pkt_phase = AWAIT_HEADER;
        pkt_left = 0;
        row_pos = img_h - 1;
        col_pos = 0;
        img_finished = 1'b0;
        decoded++;
      end
      OP_BYTE: begin
        if (!img_finished) begin
          decoded++;
          case (pkt_phase)
            AWAIT_RAW: begin
              n = paint_run(1, pal_shadow[beat.byte_value]);
              if (pkt_left > 0) pkt_left--;
              if (pkt_left == 0) pkt_phase = AWAIT_HEADER;
            end
            AWAIT_RUN: begin
              n = paint_run(pkt_left, pal_shadow[beat.byte_value]);
              pkt_left = 0;
              pkt_phase = AWAIT_HEADER;
            end
            default: begin
              pkt_left = (beat.byte_value & COUNT_MASK) + 1;
              pkt_phase = ((beat.byte_value & RUN_FLAG) != 0) ? AWAIT_RUN : AWAIT_RAW;
            end
          endcase
        end
      end
      default: ;
    endcase
    if (n > 0) begin
      tail = pending_segs.pop_back();
      tail.last_of_item = 1'b1;
      pending_segs.push_back(tail);
    end
  endfunction

  function automatic void report_segment(input string what, input seg_t want, input seg_t seen);
    errors++;
    if (errors <= 10) begin
      $display("%s: expected row %0d col %0d len %0d colour %06h last %0b done %0b",
               what, want.row, want.column, want.length, want.color, want.last_of_item,
               want.image_done);
      $display("  got row %0d col %0d len %0d colour %06h last %0b done %0b",
               seen.row, seen.column, seen.length, seen.color, seen.last_of_item,
               seen.image_done);
    end
  endfunction

  always @(posedge clk) begin
    seg_t seen;
    seg_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) decode_beat(in_beat_t'(s_tdata[$bits(in_beat_t)-1:0]));
      if (m_tvalid && m_tready) begin
        seen = {m_tuser, m_tlast, m_tdata[$bits(seg_t)-3:0]};
        segs_seen++;
        if (seen.image_done) images_done++;
        if (pending_segs.size() == 0) begin
          report_segment("unexpected segment", '0, seen);
        end else begin
          want = pending_segs.pop_front();
          if (seen !== want) report_segment("segment mismatch", want, seen);
        end
      end
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [7:0] byte_value,
                           input logic [7:0] pal_index, input logic [COLOR_W-1:0] pal_color);
    in_beat_t beat;
    beat.op = op;
    beat.byte_value = byte_value;
    beat.pal_index = pal_index;
    beat.pal_color = pal_color;
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    s_tdata <= {6'b0, beat};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_byte(input logic [7:0] value);
    send_item(OP_BYTE, value, 8'($urandom), COLOR_W'($urandom));
  endtask

  task automatic send_start();
    send_item(OP_START, 8'($urandom), 8'($urandom), COLOR_W'($urandom));
  endtask

  // drop valid and hold until the output side has been quiet for a while
  task automatic settle();
    int unsigned quiet;
    quiet = 0;
    s_tvalid <= 1'b0;
    while (quiet < QUIET_CYCLES) begin
      @(posedge clk);
      quiet = (pending_segs.size() == 0) ? quiet + 1 : 0;
    end
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [DIM_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {21'b0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == WIDTH_ADDR) width_reg = value;
    else height_reg = value;
    @(posedge clk);
  endtask

  task automatic set_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    settle();
    write_reg(WIDTH_ADDR, w);
    write_reg(HEIGHT_ADDR, h);
    size_changes++;
  endtask

  task automatic test_ignored_before_start();
    send_byte(8'h00);
    send_byte(8'hff);
    send_item(OP_UNUSED, 8'($urandom), 8'($urandom), COLOR_W'($urandom));
  endtask

  task automatic test_palette_load();
    for (int i = 0; i < PAL_DEPTH; i++) begin
      if (i == 0) send_item(OP_PAL, 8'($urandom), 8'(i), '0);
      else if (i == PAL_DEPTH - 1) send_item(OP_PAL, 8'($urandom), 8'(i), '1);
      else send_item(OP_PAL, 8'($urandom), 8'(i), COLOR_W'($urandom));
    end
  endtask

  task automatic test_small_image();
    set_size(11'd3, 11'd2);
    send_start();
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(RUN_FLAG);
    send_byte(8'hff);
    send_byte(8'h01);
    send_byte(8'ha5);
    send_byte(8'h5a);
    // long run overflows the image: tail dropped
    send_byte(8'hff);
    send_byte(8'h7f);
    send_byte(8'h3c);
    send_item(OP_UNUSED, 8'($urandom), 8'($urandom), COLOR_W'($urandom));
    send_start();
    send_byte(8'h84);
    send_byte(8'h33);
    // new size applies only from the next start
    set_size(11'd0, 11'd0);
    send_byte(8'h00);
    send_byte(8'h12);
    send_start();
    send_byte(8'h82);
    send_byte(8'hc3);
  endtask

  task automatic test_max_width();
    set_size(11'd2047, 11'd1);
    send_start();
    repeat (8) begin
      send_byte(8'hff);
      send_byte(8'($urandom));
    end
    set_size(11'd1024, 11'd2047);
    send_start();
    send_byte(8'hff);
    send_byte(8'h80);
  endtask

  task automatic test_random_images(input int unsigned item_goal);
    int unsigned first;
    int unsigned budget;
    int unsigned roll;
    int unsigned pixels;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [7:0] hdr;
    first = decoded;
    while (decoded - first < item_goal) begin
      roll = $urandom_range(99);
      if (roll < 75) begin
        w = 11'($urandom_range(12, 3));
        h = 11'($urandom_range(4, 1));
      end else if (roll < 87) begin
        w = $urandom_range(1) ? 11'($urandom_range(2)) : 11'($urandom_range(2047, 1025));
        h = $urandom_range(1) ? 11'd0 : 11'($urandom_range(2047, 1025));
        if ($urandom_range(2) == 0) h = 11'($urandom_range(3, 1));
      end else begin
        w = 11'($urandom_range(1024, 1000));
        h = 11'($urandom_range(1024, 1020));
      end
      set_size(w, h);
      send_start();
      budget = decoded + $urandom_range(50, 10);
      while (!img_finished && decoded < budget && decoded - first < item_goal) begin
        roll = $urandom_range(99);
        if (roll < 4) begin
          send_item(OP_UNUSED, 8'($urandom), 8'($urandom), COLOR_W'($urandom));
        end else if (roll < 8) begin
          send_item(OP_PAL, 8'($urandom), 8'($urandom), COLOR_W'($urandom));
        end else if (roll < 10) begin
          send_start();
        end else if (roll < 13) begin
          send_byte(8'($urandom));
        end else begin
          hdr[7] = 1'($urandom_range(1));
          if (hdr[7]) hdr[6:0] = ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(7));
          else hdr[6:0] = ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(5));
          send_byte(hdr);
          if (hdr[7]) begin
            send_byte(8'($urandom));
          end else begin
            pixels = hdr[6:0] + 1;
            // occasionally cut the packet short
            while (pixels > 0 && !img_finished && $urandom_range(49) != 0) begin
              send_byte(8'($urandom));
              pixels--;
            end
          end
        end
      end
      if (img_finished && $urandom_range(3) == 0) send_byte(8'($urandom));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct = 6;
    rx_idle_pct = 45;
    test_ignored_before_start();
    test_palette_load();
    test_small_image();
    test_max_width();
    test_random_images(10);

    tx_idle_pct = 45;
    rx_idle_pct = 6;
    test_random_images(10);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_images(10);

    settle();
    if (pending_segs.size() != 0) errors++;
    $display("Checked %0d segments, %0d of them finishing an image, from %0d decoded beats",
             segs_seen, images_done, decoded);
    $display("Covered %0d image size settings including clipped and maximum sizes",
             size_changes);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
